[hw/rtl/zyr_pkg.sv]
// Shared constants, codes and tables for the Z-Y rotation pose core.
package zyr_pkg;

	localparam logic [2:0] MODE_SET_BOTH  = 3'd0;
	localparam logic [2:0] MODE_SET_Z     = 3'd1;
	localparam logic [2:0] MODE_SET_Y     = 3'd2;
	localparam logic [2:0] MODE_ADD_Z     = 3'd3;
	localparam logic [2:0] MODE_ADD_Y     = 3'd4;
	localparam logic [2:0] MODE_RECOMPUTE = 3'd5;

	localparam logic [2:0] CFG_CENTER_X = 3'd0;
	localparam logic [2:0] CFG_CENTER_Y = 3'd1;
	localparam logic [2:0] CFG_CENTER_Z = 3'd2;
	localparam logic [2:0] CFG_REF_X    = 3'd3;
	localparam logic [2:0] CFG_REF_Y    = 3'd4;
	localparam logic [2:0] CFG_REF_Z    = 3'd5;

	localparam int NUM_ATAN = 24;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;

	function automatic logic signed [33:0] atan_val(input logic [4:0] idx);
		logic signed [33:0] v;
		case (idx)
			5'd0:  v = 34'sd536870912;
			5'd1:  v = 34'sd316933406;
			5'd2:  v = 34'sd167458907;
			5'd3:  v = 34'sd85004756;
			5'd4:  v = 34'sd42667331;
			5'd5:  v = 34'sd21354465;
			5'd6:  v = 34'sd10679838;
			5'd7:  v = 34'sd5340245;
			5'd8:  v = 34'sd2670163;
			5'd9:  v = 34'sd1335087;
			5'd10: v = 34'sd667544;
			5'd11: v = 34'sd333772;
			5'd12: v = 34'sd166886;
			5'd13: v = 34'sd83443;
			5'd14: v = 34'sd41721;
			5'd15: v = 34'sd20860;
			5'd16: v = 34'sd10430;
			5'd17: v = 34'sd5215;
			5'd18: v = 34'sd2607;
			5'd19: v = 34'sd1303;
			5'd20: v = 34'sd651;
			5'd21: v = 34'sd325;
			5'd22: v = 34'sd162;
			5'd23: v = 34'sd81;
			default: v = 34'sd0;
		endcase
		return v;
	endfunction

endpackage

[hw/rtl/zyr_cordic.sv]
// Iterative CORDIC unit: one rotation step per cycle, Q2.30 cosine and sine.
module zyr_cordic #(
	parameter int ANGLE_BITS      = 16,
	parameter int TRIG_ITERATIONS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [ANGLE_BITS-1:0] ang,
	output logic                  done,
	output logic signed [31:0]    cos_out,
	output logic signed [31:0]    sin_out
);

	logic signed [33:0] x_q, y_q, z_q;
	logic [4:0]         i_q;
	logic               run_q, neg_q, done_q;

	logic [31:0]        t0, t1;
	logic               fold;
	logic signed [33:0] xs, ys, at, xc, yc;

	assign t0   = 32'(ang) << (32 - ANGLE_BITS);
	assign fold = t0[31] ^ t0[30];
	assign t1   = {t0[31] ^ fold, t0[30:0]};

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = zyr_pkg::atan_val(i_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			i_q    <= '0;
			x_q    <= '0;
			y_q    <= '0;
			z_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				neg_q <= fold;
				i_q   <= '0;
				x_q   <= zyr_pkg::CORDIC_GAIN;
				y_q   <= '0;
				z_q   <= {{2{t1[31]}}, t1};
			end else if (run_q) begin
				if (!z_q[33]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end
				if (i_q == 5'(TRIG_ITERATIONS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					i_q <= i_q + 5'd1;
				end
			end
		end
	end

	always_comb begin
		xc = x_q;
		yc = y_q;
		if (x_q > zyr_pkg::ONE_Q30) xc = zyr_pkg::ONE_Q30;
		if (x_q < -zyr_pkg::ONE_Q30) xc = -zyr_pkg::ONE_Q30;
		if (y_q > zyr_pkg::ONE_Q30) yc = zyr_pkg::ONE_Q30;
		if (y_q < -zyr_pkg::ONE_Q30) yc = -zyr_pkg::ONE_Q30;
		if (neg_q) begin
			xc = -xc;
			yc = -yc;
		end
	end

	assign cos_out = xc[31:0];
	assign sin_out = yc[31:0];
	assign done    = done_q;

endmodule

[hw/rtl/zyr_isqrt.sv]
// Bit-pair iterative integer square root of a 64-bit value.
module zyr_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] val,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] v_q, r_q, bit_q;
	logic [4:0]  cnt_q;
	logic        run_q, done_q;
	logic [63:0] trial;

	assign trial = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			v_q    <= '0;
			r_q    <= '0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				v_q   <= val;
				r_q   <= '0;
				bit_q <= 64'd1 << 62;
			end else if (run_q) begin
				if (v_q >= trial) begin
					v_q <= v_q - trial;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (cnt_q == 5'd31) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 5'd1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = r_q[31:0];

endmodule

[hw/rtl/zyr_div.sv]
// Restoring divider: 32 quotient bits, one per cycle; high numerator word below divisor.
module zyr_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [31:0] quo
);

	logic [31:0] rem_q, lo_q, den_q;
	logic [4:0]  cnt_q;
	logic        run_q, done_q;
	logic [32:0] trial, diff;
	logic        ge;

	assign trial = {rem_q, lo_q[31]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			lo_q   <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				rem_q <= num[63:32];
				lo_q  <= num[31:0];
				den_q <= den;
			end else if (run_q) begin
				rem_q <= ge ? diff[31:0] : trial[31:0];
				lo_q  <= {lo_q[30:0], ge};
				if (cnt_q == 5'd31) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 5'd1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = lo_q;

endmodule

[hw/rtl/zy_rotation_pose_about_center_core.sv]
// Top level: Z-Y rotation of a reference point about a center, one shared multiplier.
//
// Usage:
//  s_* carries one command: s_tuser holds the mode, s_tdata the Z and Y angles.
//  Modes set both angles, set Z, set Y, add to Z, add to Y, or only recompute.
//  m_* carries one result per command: rotated point plus center (Q16.16,
//  saturated), rotated unit normal (Q2.14) and the held angles.
//  cfg_* writes center and reference registers; write only while idle.
//  Rate: one command at a time; a zero reference skips the square root and
//  the divides. The multiplier is one registered unit; the CORDIC, root and
//  divider are each one iterative unit. All are stepped by the sequencer.
//  Reset clears the angles to zero, the center to zero and the reference to
//  (-1, 0, 0). A finished result waits in the output register while the
//  receiver stalls; the next command is taken meanwhile and holds in its last
//  step until the output register frees.
module zy_rotation_pose_about_center_core #(
	parameter int ANGLE_BITS      = 16,
	parameter int TRIG_ITERATIONS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [2:0]   s_tuser,   // mode
	input  logic [31:0]  s_tdata,   // angle_z_in, angle_y_in
	output logic         m_tvalid,
	input  logic         m_tready,
	// point_x, point_y, point_z, normal_x, normal_y, normal_z, angle_z_out, angle_y_out
	output logic [175:0] m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_CORD = 8'b0000_0010,
		ST_NORM = 8'b0000_0100,
		ST_MULA = 8'b0000_1000,
		ST_SQRT = 8'b0001_0000,
		ST_DIV  = 8'b0010_0000,
		ST_MAT  = 8'b0100_0000,
		ST_OUT  = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [31:0]           cfg_q [6];
	logic [ANGLE_BITS-1:0] az_q, ay_q;
	logic signed [31:0]    cz_q, sz_q, cy_q, sy_q;
	logic signed [31:0]    p_q [4];
	logic [31:0]           u_q [3];
	logic [31:0]           m_q, len_q;
	logic                  zero_q;
	logic [63:0]           sum_q;
	logic signed [32:0]    n_q [3];
	logic signed [49:0]    acc_q;
	logic signed [63:0]    nacc_q;
	logic [31:0]           pt_q [3];
	logic [15:0]           nm_q [3];
	logic signed [65:0]    prod_q;
	logic                  ph_q, yph_q, t_q, m_tvalid_q;
	logic [2:0]            k_q;
	logic [1:0]            i_q, j_q;
	logic [175:0]          m_tdata_q;

	logic [31:0]           az32, ay32;
	logic [ANGLE_BITS-1:0] az_in, ay_in;
	logic [31:0]           abs_ref [3];
	logic [32:0]           neg_ref [3];
	logic [31:0]           max01, max012;

	logic                  cord_start, cord_done, sq_start, sq_done, dv_start, dv_done;
	logic signed [31:0]    cord_cos, cord_sin;
	logic [31:0]           sq_root, dv_quo, u_sel;
	logic [63:0]           dv_num;

	logic signed [32:0]    mul_a, mul_b;
	logic signed [31:0]    r_ent;
	logic signed [65:0]    r30, sh14;
	logic signed [49:0]    acc_n, acc_r;
	logic signed [33:0]    p_rnd;
	logic signed [34:0]    p_sum;
	logic [31:0]           p_sat;
	logic signed [63:0]    nacc_n, nacc_r;
	logic signed [17:0]    n_rnd;
	logic [15:0]           n_sat;
	logic [31:0]           center_i;
	logic signed [32:0]    q_ext;
	logic                  out_free;

	assign az32  = {16'd0, s_tdata[15:0]};
	assign ay32  = {16'd0, s_tdata[31:16]};
	assign az_in = az32[ANGLE_BITS-1:0];
	assign ay_in = ay32[ANGLE_BITS-1:0];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			neg_ref[j] = -{cfg_q[3+j][31], cfg_q[3+j]};
			abs_ref[j] = cfg_q[3+j][31] ? neg_ref[j][31:0] : cfg_q[3+j];
		end
		max01  = (abs_ref[0] > abs_ref[1]) ? abs_ref[0] : abs_ref[1];
		max012 = (max01 > abs_ref[2]) ? max01 : abs_ref[2];
	end

	assign cord_start = (state_q == ST_CORD) && !ph_q;
	assign sq_start   = (state_q == ST_SQRT) && !ph_q;
	assign dv_start   = (state_q == ST_DIV) && !ph_q;

	assign u_sel  = u_q[k_q[1:0]];
	assign dv_num = ({32'd0, u_sel} << 30) + {33'd0, len_q[31:1]};

	zyr_cordic #(
		.ANGLE_BITS     (ANGLE_BITS),
		.TRIG_ITERATIONS(TRIG_ITERATIONS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.ang    (yph_q ? ay_q : az_q),
		.done   (cord_done),
		.cos_out(cord_cos),
		.sin_out(cord_sin)
	);

	zyr_isqrt u_isqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sq_start),
		.val   (sum_q),
		.done  (sq_done),
		.root  (sq_root)
	);

	zyr_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (dv_start),
		.num   (dv_num),
		.den   (len_q),
		.done  (dv_done),
		.quo   (dv_quo)
	);

	// Rotation matrix entry for row i, column j.
	always_comb begin
		case ({i_q, j_q})
			4'b0000: r_ent = p_q[0];
			4'b0001: r_ent = -sz_q;
			4'b0010: r_ent = p_q[1];
			4'b0100: r_ent = p_q[2];
			4'b0101: r_ent = cz_q;
			4'b0110: r_ent = p_q[3];
			4'b1000: r_ent = -sy_q;
			4'b1010: r_ent = cy_q;
			default: r_ent = '0;
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_MULA) begin
			case (k_q)
				3'd0: begin
					mul_a = {cz_q[31], cz_q};
					mul_b = {cy_q[31], cy_q};
				end
				3'd1: begin
					mul_a = {cz_q[31], cz_q};
					mul_b = {sy_q[31], sy_q};
				end
				3'd2: begin
					mul_a = {sz_q[31], sz_q};
					mul_b = {cy_q[31], cy_q};
				end
				3'd3: begin
					mul_a = {sz_q[31], sz_q};
					mul_b = {sy_q[31], sy_q};
				end
				3'd4: begin
					mul_a = {1'b0, u_q[0]};
					mul_b = {1'b0, u_q[0]};
				end
				3'd5: begin
					mul_a = {1'b0, u_q[1]};
					mul_b = {1'b0, u_q[1]};
				end
				3'd6: begin
					mul_a = {1'b0, u_q[2]};
					mul_b = {1'b0, u_q[2]};
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end else if (state_q == ST_MAT) begin
			mul_a = {r_ent[31], r_ent};
			mul_b = t_q ? n_q[j_q] : {cfg_q[3+j_q][31], cfg_q[3+j_q]};
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Accumulation, rounding and saturation of one finished row; signed divider quotient.
	always_comb begin
		r30      = (prod_q + 66'sd536870912) >>> 30;
		sh14     = prod_q >>> 14;
		acc_n    = acc_q + sh14[49:0];
		nacc_n   = nacc_q + prod_q[63:0];
		acc_r    = (acc_q + 50'sd32768) >>> 16;
		p_rnd    = acc_r[33:0];
		center_i = cfg_q[{1'b0, i_q}];
		p_sum    = {p_rnd[33], p_rnd} + {{3{center_i[31]}}, center_i};
		if (p_sum > 35'sd2147483647) p_sat = 32'h7FFF_FFFF;
		else if (p_sum < -35'sd2147483648) p_sat = 32'h8000_0000;
		else p_sat = p_sum[31:0];
		nacc_r = (nacc_n + 64'sd35184372088832) >>> 46;
		n_rnd  = nacc_r[17:0];
		if (n_rnd > 18'sd16384) n_sat = 16'sd16384;
		else if (n_rnd < -18'sd16384) n_sat = -16'sd16384;
		else n_sat = n_rnd[15:0];
		q_ext = cfg_q[3+k_q[1:0]][31] ? -{1'b0, dv_quo} : {1'b0, dv_quo};
	end

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cfg_q[0]   <= '0;
			cfg_q[1]   <= '0;
			cfg_q[2]   <= '0;
			cfg_q[3]   <= 32'hFFFF_0000;
			cfg_q[4]   <= '0;
			cfg_q[5]   <= '0;
			az_q       <= '0;
			ay_q       <= '0;
			ph_q       <= 1'b0;
			yph_q      <= 1'b0;
			t_q        <= 1'b0;
			k_q        <= '0;
			i_q        <= '0;
			j_q        <= '0;
			zero_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					zyr_pkg::CFG_CENTER_X: cfg_q[0] <= cfg_data;
					zyr_pkg::CFG_CENTER_Y: cfg_q[1] <= cfg_data;
					zyr_pkg::CFG_CENTER_Z: cfg_q[2] <= cfg_data;
					zyr_pkg::CFG_REF_X:    cfg_q[3] <= cfg_data;
					zyr_pkg::CFG_REF_Y:    cfg_q[4] <= cfg_data;
					zyr_pkg::CFG_REF_Z:    cfg_q[5] <= cfg_data;
					default: ;
				endcase
			end

			if (state_q == ST_OUT && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						case (s_tuser)
							zyr_pkg::MODE_SET_BOTH: begin
								az_q <= az_in;
								ay_q <= ay_in;
							end
							zyr_pkg::MODE_SET_Z: az_q <= az_in;
							zyr_pkg::MODE_SET_Y: ay_q <= ay_in;
							zyr_pkg::MODE_ADD_Z: az_q <= az_q + az_in;
							zyr_pkg::MODE_ADD_Y: ay_q <= ay_q + ay_in;
							zyr_pkg::MODE_RECOMPUTE: ;
							default: ;
						endcase
						ph_q    <= 1'b0;
						yph_q   <= 1'b0;
						state_q <= ST_CORD;
					end
				end
				ST_CORD: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else if (cord_done) begin
						ph_q <= 1'b0;
						if (!yph_q) begin
							cz_q  <= cord_cos;
							sz_q  <= cord_sin;
							yph_q <= 1'b1;
						end else begin
							cy_q    <= cord_cos;
							sy_q    <= cord_sin;
							u_q     <= abs_ref;
							m_q     <= max012;
							zero_q  <= (max012 == 32'd0);
							state_q <= ST_NORM;
						end
					end
				end
				ST_NORM: begin
					// Shift the reference magnitudes up until the largest has bit 30 or 31 set; a zero reference is not shifted.
					if (zero_q || m_q[31] || m_q[30]) begin
						k_q     <= '0;
						ph_q    <= 1'b0;
						sum_q   <= '0;
						state_q <= ST_MULA;
					end else begin
						m_q    <= m_q << 1;
						u_q[0] <= u_q[0] << 1;
						u_q[1] <= u_q[1] << 1;
						u_q[2] <= u_q[2] << 1;
					end
				end
				ST_MULA: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ph_q <= 1'b0;
						if (k_q < 3'd4) p_q[k_q[1:0]] <= r30[31:0];
						else sum_q <= sum_q + prod_q[63:0];
						if (k_q == 3'd6) begin
							k_q <= '0;
							if (zero_q) begin
								n_q[0]  <= '0;
								n_q[1]  <= '0;
								n_q[2]  <= '0;
								i_q     <= '0;
								j_q     <= '0;
								t_q     <= 1'b0;
								acc_q   <= '0;
								nacc_q  <= '0;
								state_q <= ST_MAT;
							end else begin
								state_q <= ST_SQRT;
							end
						end else begin
							k_q <= k_q + 3'd1;
						end
					end
				end
				ST_SQRT: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else if (sq_done) begin
						ph_q    <= 1'b0;
						len_q   <= sq_root;
						k_q     <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else if (dv_done) begin
						ph_q          <= 1'b0;
						n_q[k_q[1:0]] <= q_ext;
						if (k_q == 3'd2) begin
							i_q     <= '0;
							j_q     <= '0;
							t_q     <= 1'b0;
							acc_q   <= '0;
							nacc_q  <= '0;
							state_q <= ST_MAT;
						end else begin
							k_q <= k_q + 3'd1;
						end
					end
				end
				ST_MAT: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ph_q <= 1'b0;
						t_q  <= !t_q;
						if (!t_q) begin
							acc_q <= acc_n;
						end else if (j_q != 2'd2) begin
							nacc_q <= nacc_n;
							j_q    <= j_q + 2'd1;
						end else begin
							pt_q[i_q] <= p_sat;
							nm_q[i_q] <= n_sat;
							acc_q     <= '0;
							nacc_q    <= '0;
							j_q       <= '0;
							if (i_q == 2'd2) state_q <= ST_OUT;
							else i_q <= i_q + 2'd1;
						end
					end
				end
				ST_OUT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	logic [31:0] az_out32, ay_out32;
	assign az_out32 = 32'(az_q);
	assign ay_out32 = 32'(ay_q);

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			m_tdata_q <= {ay_out32[15:0], az_out32[15:0], nm_q[2], nm_q[1], nm_q[0],
				pt_q[2], pt_q[1], pt_q[0]};
		end
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

endmodule
